>>> hw/rtl/mke_pkg.sv
// Package for the Morse keying encoder: sequencer states, character range
// constants, element lengths and the Morse code ROM. No dependencies.
`timescale 1ns / 1ps

package mke_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ELEM,
    ST_GAP
  } state_t;

  localparam logic [7:0] FIRST_CHAR   = 8'd43;
  localparam logic [7:0] LAST_CHAR    = 8'd92;
  localparam int         ROM_AW       = 6;
  localparam int         COUNT_W      = 5;
  localparam logic [4:0] LAST_UNIT_IX = 5'd19;
  localparam logic [1:0] DIT_END      = 2'd1;
  localparam logic [1:0] DAH_END      = 2'd3;
  localparam logic [1:0] CHAR_GAP     = 2'd2;
  localparam logic [1:0] WORD_GAP     = 2'd3;

  // Each code is read from bit 0 up to a leading marker 1; a 1 bit is a dit,
  // a 0 bit is a dah.
  function automatic logic [7:0] code_rom(input logic [ROM_AW-1:0] idx);
    logic [7:0] val;
    unique case (idx)
      6'd0:  val = 8'h35;
      6'd1:  val = 8'h35;
      6'd2:  val = 8'h5E;
      6'd3:  val = 8'h55;
      6'd4:  val = 8'h36;
      6'd5:  val = 8'h20;
      6'd6:  val = 8'h21;
      6'd7:  val = 8'h23;
      6'd8:  val = 8'h27;
      6'd9:  val = 8'h2F;
      6'd10: val = 8'h3F;
      6'd11: val = 8'h3E;
      6'd12: val = 8'h3C;
      6'd13: val = 8'h38;
      6'd14: val = 8'h30;
      6'd15: val = 8'h02;
      6'd16: val = 8'h02;
      6'd17: val = 8'h02;
      6'd18: val = 8'h02;
      6'd19: val = 8'h02;
      6'd20: val = 8'h73;
      6'd21: val = 8'h69;
      6'd22: val = 8'h05;
      6'd23: val = 8'h1E;
      6'd24: val = 8'h1A;
      6'd25: val = 8'h0E;
      6'd26: val = 8'h03;
      6'd27: val = 8'h1B;
      6'd28: val = 8'h0C;
      6'd29: val = 8'h1F;
      6'd30: val = 8'h07;
      6'd31: val = 8'h11;
      6'd32: val = 8'h0A;
      6'd33: val = 8'h1D;
      6'd34: val = 8'h04;
      6'd35: val = 8'h06;
      6'd36: val = 8'h08;
      6'd37: val = 8'h19;
      6'd38: val = 8'h14;
      6'd39: val = 8'h0D;
      6'd40: val = 8'h0F;
      6'd41: val = 8'h02;
      6'd42: val = 8'h0B;
      6'd43: val = 8'h17;
      6'd44: val = 8'h09;
      6'd45: val = 8'h16;
      6'd46: val = 8'h12;
      6'd47: val = 8'h1C;
      6'd48: val = 8'h2A;
      6'd49: val = 8'h57;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

>>> hw/rtl/morse_keying_encoder.sv
// Top level of the Morse keying encoder: a small sequencer that walks one
// character's code and emits one keying unit per word. Depends on mke_pkg.
`timescale 1ns / 1ps

// The input channel takes one ASCII character per word on in_char_code.
// Each character is turned into a run of result words, one keying unit each:
// out_key_on gives the tone for that unit and out_last_unit marks the final
// unit of the character. A character gives at most 20 units; characters
// outside the code table give a three-unit word gap.
// After a character is taken, in_stall stays high until its last unit has
// been loaded into the output register, so the block takes no new character
// while one is still being sent.
// The accepted character is first registered into the sequencer state and
// code register; its first unit is then loaded into the output register.
// A single unit counter, stepped once per unit, and a code shift register,
// stepped once per element, drive the sequence.
// When the receiver raises out_stall, the pending unit is held and the
// sequencer pauses; no unit is lost or repeated.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties
// the output register.
module morse_keying_encoder
  import mke_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_key_on,
  output logic       out_last_unit
);

  state_t             state_r, state_nxt;
  logic [7:0]         code_r, code_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [1:0]         gap_left_r, gap_left_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_key_on_r, out_key_on_nxt;
  logic               out_last_unit_r, out_last_unit_nxt;

  logic               advance;
  logic               unit_on;
  logic               unit_last;
  logic               elem_end;
  logic               cap;
  logic [7:0]         idx_full;
  logic [7:0]         rom_val;
  logic [7:0]         code_shift;

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_key_on    = out_key_on_r;
  assign out_last_unit = out_last_unit_r;

  assign advance    = (state_r != ST_IDLE) && (!out_valid_r || !out_stall);
  assign idx_full   = in_char_code - FIRST_CHAR;
  assign rom_val    = code_rom(idx_full[ROM_AW-1:0]);
  assign code_shift = code_r >> 1;
  assign cap        = (count_r == LAST_UNIT_IX);
  assign elem_end   = code_r[0] ? (phase_r == DIT_END) : (phase_r == DAH_END);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r          <= code_nxt;
    phase_r         <= phase_nxt;
    count_r         <= count_nxt;
    gap_left_r      <= gap_left_nxt;
    out_key_on_r    <= out_key_on_nxt;
    out_last_unit_r <= out_last_unit_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    gap_left_nxt = gap_left_r;
    unit_on      = 1'b0;
    unit_last    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          count_nxt = '0;
          phase_nxt = '0;
          if ((in_char_code >= FIRST_CHAR) && (in_char_code <= LAST_CHAR)) begin
            code_nxt = rom_val;
            if (rom_val > 8'd1) begin
              state_nxt = ST_ELEM;
            end else begin
              gap_left_nxt = CHAR_GAP;
              state_nxt    = ST_GAP;
            end
          end else begin
            gap_left_nxt = WORD_GAP;
            state_nxt    = ST_GAP;
          end
        end
      end
      ST_ELEM: begin
        if (advance) begin
          unit_on   = !elem_end;
          unit_last = cap;
          count_nxt = count_r + 5'd1;
          phase_nxt = elem_end ? 2'd0 : phase_r + 2'd1;
          if (elem_end) begin
            code_nxt = code_shift;
          end
          if (cap) begin
            state_nxt = ST_IDLE;
          end else if (elem_end && (code_shift <= 8'd1)) begin
            gap_left_nxt = CHAR_GAP;
            state_nxt    = ST_GAP;
          end
        end
      end
      ST_GAP: begin
        if (advance) begin
          unit_last    = (gap_left_r == 2'd1) || cap;
          count_nxt    = count_r + 5'd1;
          gap_left_nxt = gap_left_r - 2'd1;
          if (unit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt     = out_valid_r;
    out_key_on_nxt    = out_key_on_r;
    out_last_unit_nxt = out_last_unit_r;
    if (advance) begin
      out_valid_nxt     = 1'b1;
      out_key_on_nxt    = unit_on;
      out_last_unit_nxt = unit_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule
